[rtl/nps_pkg.sv]
`default_nettype none

package nps_pkg;

    localparam int MAX_POINTS_DEF = 256;

    localparam int COORD_W = 16;
    localparam int SLOT_W  = 8;
    localparam int DIST_W  = 33;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int CNT_W   = 9;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_W   = PADDR_W - 2;

    localparam logic [CNT_W-1:0] POINT_COUNT_RST = CNT_W'(2);

    localparam logic             KIND_LOAD       = 1'b0;
    localparam logic             KIND_QUERY      = 1'b1;
    localparam logic [REG_W-1:0] REG_POINT_COUNT = REG_W'(0);

    typedef struct packed {
        logic load;
        logic start;
        logic issue;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic issue_last;
        logic scan_done;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/nps_ram.sv]
`default_nettype none

module nps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/nps_ctrl.sv]
`default_nettype none

module nps_ctrl
    import nps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_kind,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_kind == KIND_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/nps_dp.sv]
`default_nettype none

module nps_dp
    import nps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_dp_cmd                   i_cmd,
    output t_dp_sts                        o_sts,
    input  wire logic [SLOT_W-1:0]         i_slot,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,
    input  wire logic [CNT_W-1:0]          i_point_count,
    output logic [SLOT_W-1:0]              o_nearest_slot,
    output logic [DIST_W-1:0]              o_nearest_dist_sq
);

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int NW   = $clog2(MAX_POINTS + 1);
    localparam int CMPW = (NW > CNT_W) ? NW : CNT_W;

    // query and scan control
    logic signed [COORD_W-1:0] r_qx, r_qy;
    logic [AW-1:0]             r_last;
    logic [AW-1:0]             r_cnt;
    logic [CMPW-1:0]           n_clamp;

    // table
    logic                 ram_we;
    logic [2*COORD_W-1:0] ram_rdata;
    logic                 slot_ok;

    // pipeline
    logic                      r_v1, r_v2, r_v3;
    logic                      r_fin1, r_fin2, r_fin3;
    logic [AW-1:0]             r_idx1, r_idx2, r_idx3;
    logic signed [COORD_W:0]   dx, dy, dx_neg, dy_neg;
    logic [COORD_W-1:0]        r_ax, r_ay;
    logic [SQ_W-1:0]           r_sqx, r_sqy;
    logic [DIST_W-1:0]         cand_d;
    logic                      take;

    // best so far and result
    logic [DIST_W-1:0] r_best_d;
    logic [AW-1:0]     r_best_i;
    logic [SLOT_W-1:0] r_out_slot;
    logic [DIST_W-1:0] r_out_dist;

    assign slot_ok = (32'(i_slot) < 32'(MAX_POINTS));
    assign ram_we  = i_cmd.load && slot_ok;

    nps_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_slot)),
        .i_wdata ({i_coord_x, i_coord_y}),
        .i_raddr (r_cnt),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_clamp = CMPW'(i_point_count);
        if (n_clamp < CMPW'(2)) begin
            n_clamp = CMPW'(2);
        end else if (n_clamp > CMPW'(MAX_POINTS)) begin
            n_clamp = CMPW'(MAX_POINTS);
        end
    end

    assign o_sts.issue_last = i_cmd.issue && (r_cnt == r_last);
    assign o_sts.scan_done  = r_v3 && r_fin3;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qx   <= i_coord_x;
            r_qy   <= i_coord_y;
            r_last <= AW'(n_clamp - CMPW'(1));
            r_cnt  <= '0;
        end else if (i_cmd.issue) begin
            r_cnt <= r_cnt + AW'(1);
        end
    end

    // absolute differences
    always_comb begin
        dx     = $signed({r_qx[COORD_W-1], r_qx})
               - $signed({ram_rdata[2*COORD_W-1], ram_rdata[2*COORD_W-1:COORD_W]});
        dy     = $signed({r_qy[COORD_W-1], r_qy})
               - $signed({ram_rdata[COORD_W-1], ram_rdata[COORD_W-1:0]});
        dx_neg = -dx;
        dy_neg = -dy;
    end

    assign cand_d = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign take   = r_v3 && ((r_idx3 == '0) || (cand_d < r_best_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_cnt;
        r_fin1 <= o_sts.issue_last;

        r_idx2 <= r_idx1;
        r_fin2 <= r_fin1;
        r_ax   <= dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
        r_ay   <= dy[COORD_W] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];

        r_idx3 <= r_idx2;
        r_fin3 <= r_fin2;
        r_sqx  <= r_ax * r_ax;
        r_sqy  <= r_ay * r_ay;

        if (take) begin
            r_best_d <= cand_d;
            r_best_i <= r_idx3;
        end

        if (i_cmd.out_load) begin
            r_out_slot <= SLOT_W'(r_best_i);
            r_out_dist <= r_best_d;
        end
    end

    assign o_nearest_slot    = r_out_slot;
    assign o_nearest_dist_sq = r_out_dist;

endmodule

`default_nettype wire

[rtl/nearest_point_search.sv]
// nearest point search over a table of 2-d reference points
//
// input channel (i_in_valid / o_in_stall) carries one item per handshake:
// a load item (i_kind = 0) writes i_coord_x / i_coord_y into table slot
// i_slot (ignored unless below MAX_POINTS) and is taken with no result; a query item
// (i_kind = 1) scans slots 0 to point_count-1 and returns one result item
// on the output channel (o_out_valid / i_out_stall): the lowest index of
// the closest slot and its squared distance
// a query passes the scan, drain and done states of the controller before
// its result is loaded to the output register, and no new item is taken
// meanwhile; point_count is held to 2..MAX_POINTS; the table memory is read
// one slot a cycle and feeds a subtract, square, add-and-compare pipeline
// the next item is taken the cycle after the result is loaded; a result
// stalled by i_out_stall waits in the output register while loads and one
// more query proceed, and that query holds its result until the register
// frees up
// point_count is written over the apb port at byte address 0, by the user
// only while the block is idle, which the block does not enforce; reset
// sets it to 2, empties both channels and leaves the table undefined until loaded
`default_nettype none

module nearest_point_search
    import nps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_kind,
    input  wire logic [SLOT_W-1:0]         i_slot,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,

    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [SLOT_W-1:0]              o_nearest_slot,
    output logic [DIST_W-1:0]              o_nearest_dist_sq,

    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [PADDR_W-1:0]        paddr,
    input  wire logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]             prdata,
    output logic                           pready
);

    logic [CNT_W-1:0] r_point_count;
    logic             reg_sel;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_POINT_COUNT);
    assign prdata  = reg_sel ? PDATA_W'(r_point_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= POINT_COUNT_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_point_count <= pwdata[CNT_W-1:0];
        end
    end

    nps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    nps_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_slot            (i_slot),
        .i_coord_x         (i_coord_x),
        .i_coord_y         (i_coord_y),
        .i_point_count     (r_point_count),
        .o_nearest_slot    (o_nearest_slot),
        .o_nearest_dist_sq (o_nearest_dist_sq)
    );

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind == KIND_QUERY) |=> o_in_stall)
        else $error("input not stalled after a query was accepted");

    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a scan in progress");

    a_no_load_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!cmd.issue && !sts.scan_done))
        else $error("table write during a scan");

    a_done_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.scan_done |=> !cmd.issue)
        else $error("table read issued after the scan finished");

endmodule

`default_nettype wire
